### rtl/olist_pkg.sv
package olist_pkg;

	// request codes
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_APPEND     = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_REMOVE     = 3'd3;
	localparam logic [2:0] REQ_SEARCH     = 3'd4;
	localparam logic [2:0] REQ_CLEAR      = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// datapath operations
	localparam logic [3:0] OP_NONE      = 4'd0;
	localparam logic [3:0] OP_LOAD      = 4'd1;
	localparam logic [3:0] OP_TAKE_BUMP = 4'd2;
	localparam logic [3:0] OP_RD_FREE   = 4'd3;
	localparam logic [3:0] OP_TAKE_FREE = 4'd4;
	localparam logic [3:0] OP_INSERT    = 4'd5;
	localparam logic [3:0] OP_LINK_TAIL = 4'd6;
	localparam logic [3:0] OP_RD_CUR    = 4'd7;
	localparam logic [3:0] OP_POP       = 4'd8;
	localparam logic [3:0] OP_STEP      = 4'd9;
	localparam logic [3:0] OP_UNLINK    = 4'd10;
	localparam logic [3:0] OP_FREE_CUR  = 4'd11;
	localparam logic [3:0] OP_CLEAR     = 4'd12;
	localparam logic [3:0] OP_RESULT    = 4'd13;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] st;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic       full;
		logic       empty;
		logic       bump_ok;
		logic       hit;
		logic       walk_end;
		logic       out_busy;
	} sts_t;

endpackage

### rtl/olist_dp.sv
module olist_dp #(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  olist_pkg::cmd_t     cmd,
	output olist_pkg::sts_t     sts,
	input  logic [2:0]          req_type,
	input  logic signed [31:0]  value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic signed [31:0]  popped_value,
	output logic [5:0]          found_index,
	output logic [6:0]          entry_count
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0]   vals_mem [CAPACITY];
	logic [IW-1:0] links_mem [CAPACITY];

	logic [2:0]    req_q;
	logic [31:0]   key_q;
	logic [31:0]   pop_val_q;
	logic [IW-1:0] head_q, tail_q, cur_q, prev_q, node_q, fhead_q;
	logic [CW-1:0] count_q, bump_q, pos_q;
	logic [31:0]   rd_val_q;
	logic [IW-1:0] rd_link_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [31:0]   popped_q;
	logic [CW-1:0] found_q, entry_q;

	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          vwr_en, lwr_en;
	logic [IW-1:0] vwr_addr, lwr_addr, lwr_data;
	logic          last_one;

	assign last_one = (count_q == CW'(1));

	// status back to the controller
	always_comb begin
		sts.req      = req_q;
		sts.full     = (count_q == CW'(CAPACITY));
		sts.empty    = (count_q == '0);
		sts.bump_ok  = (bump_q != CW'(CAPACITY));
		sts.hit      = (rd_val_q == key_q);
		sts.walk_end = (pos_q == count_q);
		sts.out_busy = out_valid_q && out_stall;
	end

	// memory port decode
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = cur_q;
		vwr_en   = 1'b0;
		vwr_addr = node_q;
		lwr_en   = 1'b0;
		lwr_addr = cur_q;
		lwr_data = fhead_q;
		case (cmd.op)
			olist_pkg::OP_RD_FREE: begin
				rd_en   = 1'b1;
				rd_addr = fhead_q;
			end
			olist_pkg::OP_RD_CUR: begin
				rd_en = 1'b1;
			end
			olist_pkg::OP_INSERT: begin
				vwr_en   = 1'b1;
				lwr_en   = 1'b1;
				lwr_addr = node_q;
				lwr_data = (req_q == olist_pkg::REQ_PUSH_FRONT && count_q != '0) ?
					head_q : '0;
			end
			olist_pkg::OP_LINK_TAIL: begin
				lwr_en   = 1'b1;
				lwr_addr = tail_q;
				lwr_data = node_q;
			end
			olist_pkg::OP_POP, olist_pkg::OP_FREE_CUR: begin
				lwr_en = 1'b1;
			end
			olist_pkg::OP_UNLINK: begin
				lwr_en   = (pos_q != '0);
				lwr_addr = prev_q;
				lwr_data = rd_link_q;
			end
			default: begin
			end
		endcase
	end

	// node store
	always_ff @(posedge clk) begin
		if (vwr_en) begin
			vals_mem[vwr_addr] <= key_q;
		end
		if (lwr_en) begin
			links_mem[lwr_addr] <= lwr_data;
		end
		if (rd_en) begin
			rd_val_q  <= vals_mem[rd_addr];
			rd_link_q <= links_mem[rd_addr];
		end
	end

	// list registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			bump_q  <= '0;
			fhead_q <= '0;
		end else begin
			case (cmd.op)
				olist_pkg::OP_TAKE_BUMP: bump_q <= bump_q + CW'(1);
				olist_pkg::OP_TAKE_FREE: fhead_q <= rd_link_q;
				olist_pkg::OP_INSERT: begin
					if (count_q == '0) begin
						head_q <= node_q;
						tail_q <= node_q;
					end else if (req_q == olist_pkg::REQ_PUSH_FRONT) begin
						head_q <= node_q;
					end
					count_q <= count_q + CW'(1);
				end
				olist_pkg::OP_LINK_TAIL: tail_q <= node_q;
				olist_pkg::OP_POP: begin
					fhead_q <= cur_q;
					count_q <= count_q - CW'(1);
					head_q  <= last_one ? '0 : rd_link_q;
					if (last_one) begin
						tail_q <= '0;
					end
				end
				olist_pkg::OP_UNLINK: begin
					if (pos_q == '0) begin
						head_q <= rd_link_q;
					end
					if (pos_q + CW'(1) == count_q) begin
						tail_q <= prev_q;
					end
				end
				olist_pkg::OP_FREE_CUR: begin
					fhead_q <= cur_q;
					count_q <= count_q - CW'(1);
					if (last_one) begin
						head_q <= '0;
						tail_q <= '0;
					end
				end
				olist_pkg::OP_CLEAR: begin
					bump_q  <= '0;
					count_q <= '0;
					head_q  <= '0;
					tail_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// request and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
			pos_q <= '0;
		end else begin
			case (cmd.op)
				olist_pkg::OP_LOAD: begin
					req_q <= req_type;
					pos_q <= '0;
				end
				olist_pkg::OP_STEP: pos_q <= pos_q + CW'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			olist_pkg::OP_LOAD: begin
				key_q  <= value;
				cur_q  <= head_q;
				prev_q <= '0;
			end
			olist_pkg::OP_TAKE_BUMP: node_q <= bump_q[IW-1:0];
			olist_pkg::OP_RD_FREE: node_q <= fhead_q;
			olist_pkg::OP_POP: pop_val_q <= rd_val_q;
			olist_pkg::OP_STEP: begin
				prev_q <= cur_q;
				cur_q  <= rd_link_q;
			end
			default: begin
			end
		endcase
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == olist_pkg::OP_RESULT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == olist_pkg::OP_RESULT) begin
			status_q <= cmd.st;
			popped_q <= (req_q == olist_pkg::REQ_POP_FRONT && cmd.st == olist_pkg::ST_OK) ?
				pop_val_q : '0;
			found_q  <= (req_q == olist_pkg::REQ_SEARCH && cmd.st == olist_pkg::ST_OK) ?
				pos_q : '0;
			entry_q  <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign found_index  = 6'(found_q);
	assign entry_count  = 7'(entry_q);

endmodule

### rtl/olist_ctrl.sv
module olist_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  olist_pkg::sts_t sts,
	output olist_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_ALLOC    = 4'd2;
	localparam logic [3:0] S_INSERT   = 4'd3;
	localparam logic [3:0] S_LINK     = 4'd4;
	localparam logic [3:0] S_POP      = 4'd5;
	localparam logic [3:0] S_WALK_RD  = 4'd6;
	localparam logic [3:0] S_WALK_CMP = 4'd7;
	localparam logic [3:0] S_FREE     = 4'd8;
	localparam logic [3:0] S_RESULT   = 4'd9;

	logic [3:0] state_q, state_d;
	logic [1:0] st_q, st_d;

	assign in_stall = (state_q != S_IDLE);

	// next state and command
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd.op  = olist_pkg::OP_NONE;
		cmd.st  = st_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = olist_pkg::OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				st_d    = olist_pkg::ST_OK;
				state_d = S_RESULT;
				case (sts.req)
					olist_pkg::REQ_PUSH_FRONT, olist_pkg::REQ_APPEND: begin
						if (sts.full) begin
							st_d = olist_pkg::ST_FULL;
						end else if (sts.bump_ok) begin
							cmd.op  = olist_pkg::OP_TAKE_BUMP;
							state_d = S_INSERT;
						end else begin
							cmd.op  = olist_pkg::OP_RD_FREE;
							state_d = S_ALLOC;
						end
					end
					olist_pkg::REQ_POP_FRONT: begin
						if (sts.empty) begin
							st_d = olist_pkg::ST_EMPTY;
						end else begin
							cmd.op  = olist_pkg::OP_RD_CUR;
							state_d = S_POP;
						end
					end
					olist_pkg::REQ_REMOVE, olist_pkg::REQ_SEARCH: begin
						state_d = S_WALK_RD;
					end
					olist_pkg::REQ_CLEAR: begin
						cmd.op = olist_pkg::OP_CLEAR;
					end
					default: begin
					end
				endcase
			end
			S_ALLOC: begin
				cmd.op  = olist_pkg::OP_TAKE_FREE;
				state_d = S_INSERT;
			end
			S_INSERT: begin
				cmd.op  = olist_pkg::OP_INSERT;
				state_d = (sts.req == olist_pkg::REQ_APPEND && !sts.empty) ? S_LINK : S_RESULT;
			end
			S_LINK: begin
				cmd.op  = olist_pkg::OP_LINK_TAIL;
				state_d = S_RESULT;
			end
			S_POP: begin
				cmd.op  = olist_pkg::OP_POP;
				state_d = S_RESULT;
			end
			S_WALK_RD: begin
				if (sts.walk_end) begin
					st_d    = olist_pkg::ST_NOT_FOUND;
					state_d = S_RESULT;
				end else begin
					cmd.op  = olist_pkg::OP_RD_CUR;
					state_d = S_WALK_CMP;
				end
			end
			S_WALK_CMP: begin
				if (!sts.hit) begin
					cmd.op  = olist_pkg::OP_STEP;
					state_d = S_WALK_RD;
				end else if (sts.req == olist_pkg::REQ_SEARCH) begin
					state_d = S_RESULT;
				end else begin
					cmd.op  = olist_pkg::OP_UNLINK;
					state_d = S_FREE;
				end
			end
			S_FREE: begin
				cmd.op  = olist_pkg::OP_FREE_CUR;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!sts.out_busy) begin
					cmd.op  = olist_pkg::OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= olist_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

endmodule

### rtl/ordered_list_engine.sv
// Bounded singly linked list of signed 32-bit values in a node store of CAPACITY
// entries. One request word in, one result word out. Nodes are handed out first
// from a fill counter and then from a free list threaded through the link store,
// so no clearing pass is needed after reset or clear. Timing comes from the
// one-read-port node store. Push front and append take a node from the fill
// counter, or from the free list once it is spent; append to a non-empty list
// also links the old tail. Pop front reads the head node; clear and unknown
// requests go straight to the result. Search and remove key read and compare
// each node in turn from the head, so a missing key walks every entry. A new
// request is taken while the previous result word still waits; the input stalls
// while a request is in progress, and a finished result waits for the output.
module ordered_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] popped_value,
	output logic [5:0]         found_index,
	output logic [6:0]         entry_count
);

	olist_pkg::cmd_t cmd;
	olist_pkg::sts_t sts;

	olist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	olist_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.popped_value (popped_value),
		.found_index  (found_index),
		.entry_count  (entry_count)
	);

endmodule
